FILE: sv/fhad_pkg.sv
// fhad_pkg: shared types and constants for the frame history averager
// no dependencies; imported by every module of the block

package fhad_pkg;

    // widths fixed by the word fields
    localparam int SAMPLE_W = 32;
    localparam int CNT_W    = 9;    // holds any averaging count up to 256
    localparam int SUM_W    = 41;   // 32-bit words summed over up to 256 slots

    // 0.001 in q16.16 and the decibel scale factors in q.24
    localparam logic signed [32:0] OFFSET_Q16 = 33'sd66;
    localparam logic signed [27:0] K10_Q24    = 28'sd50504453;
    localparam logic signed [27:0] K20_Q24    = 28'sd101008905;

    // register indexes
    localparam logic [1:0] REG_AVG_COUNT = 2'd0;
    localparam logic [1:0] REG_LOG_MODE  = 2'd1;
    localparam logic [1:0] REG_REJECT    = 2'd2;
    localparam logic [1:0] REG_PAUSE     = 2'd3;

    // log mode codes
    localparam logic [1:0] LOG_TEN    = 2'd1;
    localparam logic [1:0] LOG_TWENTY = 2'd2;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_WRITE = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_LOG   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } fhad_state_t;

    typedef enum logic [3:0] {
        LG_IDLE  = 4'b0001,
        LG_NORM  = 4'b0010,
        LG_SQ    = 4'b0100,
        LG_MUL   = 4'b1000
    } fhad_log_state_t;

endpackage

FILE: sv/fhad_div.sv
// fhad_div: signed sum divided by the averaging count, rounded to nearest
// bit-serial restoring divider; depends on fhad_pkg

module fhad_div
    import fhad_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    sum,
    input  logic [CNT_W-1:0]           count,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] quotient
);

    localparam int DVD_W  = SUM_W + 1;
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                neg_reg, neg_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [CNT_W:0]      rem_reg, rem_next;
    logic [CNT_W:0]      den_reg, den_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic [SUM_W-1:0]    mag;
    logic [CNT_W:0]      rem_shift;
    logic [SAMPLE_W:0]   q_signed;

    always_comb begin
        mag       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        rem_shift = {rem_reg[CNT_W-1:0], dvd_reg[DVD_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            neg_next  = sum[SUM_W-1];
            dvd_next  = {1'b0, mag} + DVD_W'(count >> 1);
            rem_next  = '0;
            den_next  = {1'b0, count};
            step_next = '0;
        end else if (busy_reg) begin
            if (rem_shift >= den_reg) begin
                rem_next = rem_shift - den_reg;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
    end

    // mean magnitude never exceeds 2^31, so the low bits carry it
    assign q_signed = neg_reg ? -{1'b0, dvd_reg[SAMPLE_W-1:0]} : {1'b0, dvd_reg[SAMPLE_W-1:0]};
    assign quotient = q_signed[SAMPLE_W-1:0];
    assign done     = done_reg;

endmodule

FILE: sv/fhad_log.sv
// fhad_log: decibel value of a positive q16.16 argument
// normalise, 24 squarings, scale by k; depends on fhad_pkg

module fhad_log
    import fhad_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [SAMPLE_W-1:0]        arg,
    input  logic                       twenty,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] value
);

    fhad_log_state_t     st_reg, st_next;
    logic                done_reg, done_next;
    logic [31:0]         y_reg, y_next;
    logic [4:0]          e_reg, e_next;
    logic [23:0]         frac_reg, frac_next;
    logic [4:0]          it_reg, it_next;
    logic                twenty_reg, twenty_next;
    logic signed [57:0]  prod_reg, prod_next;

    logic [63:0]         sq;
    logic [32:0]         sq_sh;
    logic signed [29:0]  l2;
    logic [57:0]         pmag;
    logic [25:0]         qmag;
    logic [26:0]         qs;

    always_comb begin
        sq          = 64'(y_reg) * 64'(y_reg);
        sq_sh       = sq[63:31];
        l2          = {6'({1'b0, e_reg} - 6'd16), frac_reg};
        st_next     = st_reg;
        done_next   = 1'b0;
        y_next      = y_reg;
        e_next      = e_reg;
        frac_next   = frac_reg;
        it_next     = it_reg;
        twenty_next = twenty_reg;
        prod_next   = prod_reg;
        case (st_reg)
            LG_IDLE: begin
                if (start) begin
                    y_next      = arg;
                    e_next      = 5'd31;
                    frac_next   = '0;
                    it_next     = '0;
                    twenty_next = twenty;
                    st_next     = LG_NORM;
                end
            end
            LG_NORM: begin
                if (y_reg[31]) begin
                    st_next = LG_SQ;
                end else begin
                    y_next = {y_reg[30:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            LG_SQ: begin
                if (sq_sh[32]) begin
                    y_next    = sq_sh[32:1];
                    frac_next = {frac_reg[22:0], 1'b1};
                end else begin
                    y_next    = sq_sh[31:0];
                    frac_next = {frac_reg[22:0], 1'b0};
                end
                it_next = it_reg + 1'b1;
                if (it_reg == 5'd23) begin
                    st_next = LG_MUL;
                end
            end
            LG_MUL: begin
                prod_next = 58'(l2) * 58'(twenty_reg ? K20_Q24 : K10_Q24);
                done_next = 1'b1;
                st_next   = LG_IDLE;
            end
            default: st_next = LG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= LG_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        y_reg      <= y_next;
        e_reg      <= e_next;
        frac_reg   <= frac_next;
        it_reg     <= it_next;
        twenty_reg <= twenty_next;
        prod_reg   <= prod_next;
    end

    // q.24 times q.24 to q16.16, ties away from zero
    always_comb begin
        pmag  = prod_reg[57] ? 58'(-prod_reg) : 58'(prod_reg);
        qmag  = 26'((pmag + 58'h0_8000_0000) >> 32);
        qs    = prod_reg[57] ? -{1'b0, qmag} : {1'b0, qmag};
        value = SAMPLE_W'(signed'(qs));
    end

    assign done = done_reg;

endmodule

FILE: sv/frame_history_averager_db_core.sv
// frame_history_averager_db_core: boxcar average over a frame history
// with optional decibel output; uses fhad_pkg, fhad_div and fhad_log

// Each accepted word is stored in the current history slot at its channel
// and bin, then the block reads that bin from every active slot out of one
// history memory with a write port and a read port (one read a cycle),
// divides the sum by the averaging count in a bit-serial divider and, in a
// log mode, runs a normalise-and-square log2 unit. The memory read loop and
// the serial divider, with the log2 unit in log mode, set how long an item
// takes; the block finishes one word's result before it takes the next. A
// new word is taken while the previous result still waits on the output
// register. After reset the whole history memory is cleared, one word a
// cycle; writing averaging_count clears the slots above it the same way.
// No word is accepted while clearing, but register writes are.

module frame_history_averager_db_core
    import fhad_pkg::*;
#(
    parameter int MAX_HISTORY  = 64,
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_BINS     = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // apb-style register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input words
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_channel,
    input  logic [11:0]                s_bin_index,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic                       s_frame_done,
    // result words
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_out_channel,
    output logic [11:0]                m_out_bin,
    output logic signed [SAMPLE_W-1:0] m_mean_value,
    output logic                       m_log_invalid,
    output logic                       m_out_frame_done
);

    localparam int SLOT_AW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int SLOT_CW = $clog2(MAX_HISTORY + 1);
    localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BIN_AW  = $clog2(MAX_BINS);
    localparam int LOW_W   = CH_AW + BIN_AW;
    localparam int ADDR_W  = SLOT_AW + LOW_W;
    localparam int DEPTH   = 1 << ADDR_W;

    // registers
    logic [6:0]            avg_count_reg, avg_count_next;
    logic [1:0]            log_mode_reg, log_mode_next;
    logic                  reject_reg, reject_next;
    logic                  pause_reg, pause_next;
    logic [SLOT_AW-1:0]    wslot_reg, wslot_next;

    // sequencer
    fhad_state_t           st_reg, st_next;
    logic [SLOT_CW-1:0]    clr_slot_reg, clr_slot_next;
    logic [LOW_W-1:0]      clr_low_reg, clr_low_next;
    logic [CNT_W-1:0]      rd_slot_reg, rd_slot_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic                  inv_reg, inv_next;

    // captured word
    logic [2:0]            it_ch_reg;
    logic [11:0]           it_bin_reg;
    logic signed [SAMPLE_W-1:0] it_val_reg;
    logic                  it_done_reg;

    // result register
    logic                  mv_reg, mv_next;
    logic [2:0]            mo_ch_reg;
    logic [11:0]           mo_bin_reg;
    logic signed [SAMPLE_W-1:0] mo_val_reg;
    logic                  mo_inv_reg;
    logic                  mo_done_reg;
    logic                  mo_load;

    // history memory
    logic [SAMPLE_W-1:0]   mem [0:DEPTH-1];
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [SAMPLE_W-1:0]   mem_wd;
    logic [ADDR_W-1:0]     mem_ra;
    logic [SAMPLE_W-1:0]   mem_rd_reg;

    // units
    logic                  div_start, div_done;
    logic                  log_start, log_done;
    logic signed [SAMPLE_W-1:0] div_q;
    logic signed [SAMPLE_W-1:0] log_val;
    logic signed [32:0]    log_arg;

    logic                  cfg_wr;
    logic [1:0]            cfg_idx;
    logic [CNT_W-1:0]      n_eff;
    logic [CNT_W-1:0]      n_new;
    logic                  in_range;
    logic [SLOT_AW-1:0]    cur_slot;
    logic [LOW_W-1:0]      item_low;
    logic                  log_on;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [6:0] v);
        logic [CNT_W-1:0] n;
        n = CNT_W'(v);
        if (n == '0) n = CNT_W'(1);
        if (32'(n) > 32'(MAX_HISTORY)) n = CNT_W'(MAX_HISTORY);
        return n;
    endfunction

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];
    assign n_eff   = clamp_count(avg_count_reg);
    assign n_new   = clamp_count(pwdata[6:0]);
    // no word is taken in the cycle of a register write
    assign s_ready = (st_reg == ST_IDLE) && !cfg_wr;
    assign in_range = (32'(s_channel) < 32'(MAX_CHANNELS))
                    && (32'(s_bin_index) < 32'(MAX_BINS));
    assign cur_slot = (CNT_W'(wslot_reg) >= n_eff) ? '0 : wslot_reg;
    assign item_low = {CH_AW'(it_ch_reg), BIN_AW'(it_bin_reg)};
    assign log_on   = (log_mode_reg == LOG_TEN) || (log_mode_reg == LOG_TWENTY);
    assign log_arg  = {div_q[SAMPLE_W-1], div_q} + OFFSET_Q16;
    assign mo_load  = (st_reg == ST_OUT) && !pause_reg && (!mv_reg || m_ready);

    always_comb begin
        case (cfg_idx)
            REG_AVG_COUNT: prdata = 32'(avg_count_reg);
            REG_LOG_MODE:  prdata = 32'(log_mode_reg);
            REG_REJECT:    prdata = 32'(reject_reg);
            REG_PAUSE:     prdata = 32'(pause_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        avg_count_next = avg_count_reg;
        log_mode_next  = log_mode_reg;
        reject_next    = reject_reg;
        pause_next     = pause_reg;
        wslot_next     = wslot_reg;
        st_next        = st_reg;
        clr_slot_next  = clr_slot_reg;
        clr_low_next   = clr_low_reg;
        rd_slot_next   = rd_slot_reg;
        rd_pend_next   = 1'b0;
        sum_next       = sum_reg;
        res_next       = res_reg;
        inv_next       = inv_reg;
        div_start      = 1'b0;
        log_start      = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = {clr_slot_reg[SLOT_AW-1:0], clr_low_reg};
        mem_wd         = '0;
        mem_ra         = {rd_slot_reg[SLOT_AW-1:0], item_low};
        mv_next        = mv_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (st_reg)
            ST_CLEAR: begin
                // one word a cycle from the start slot to the top
                mem_we = 1'b1;
                clr_low_next = clr_low_reg + 1'b1;
                if (clr_low_reg == '1) begin
                    clr_slot_next = clr_slot_reg + 1'b1;
                    if (32'(clr_slot_reg) == 32'(MAX_HISTORY - 1)) begin
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready && !reject_reg && in_range) begin
                    st_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // store the word, then advance the slot on frame end
                mem_we = 1'b1;
                mem_wa = {cur_slot, item_low};
                mem_wd = it_val_reg;
                wslot_next = cur_slot;
                if (it_done_reg) begin
                    wslot_next = (CNT_W'(cur_slot) + 1'b1 >= n_eff) ? '0
                                 : cur_slot + 1'b1;
                end
                rd_slot_next = '0;
                sum_next     = '0;
                st_next      = ST_READ;
            end
            ST_READ: begin
                // read data is registered and arrives the cycle after its address
                if (rd_pend_reg) begin
                    sum_next = sum_reg + SUM_W'(signed'(mem_rd_reg));
                end
                if (rd_slot_reg < n_eff) begin
                    rd_pend_next = 1'b1;
                    rd_slot_next = rd_slot_reg + 1'b1;
                end else if (!rd_pend_reg) begin
                    div_start = 1'b1;
                    st_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    inv_next = 1'b0;
                    if (!log_on) begin
                        res_next = div_q;
                        st_next  = ST_OUT;
                    end else if (log_arg[32] || log_arg == '0) begin
                        inv_next = 1'b1;
                        res_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
                        st_next  = ST_OUT;
                    end else begin
                        log_start = 1'b1;
                        st_next   = ST_LOG;
                    end
                end
            end
            ST_LOG: begin
                if (log_done) begin
                    res_next = log_val;
                    st_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                // paused: history updated, result dropped
                if (pause_reg) begin
                    st_next = ST_IDLE;
                end else if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase

        if (cfg_wr) begin
            case (cfg_idx)
                REG_AVG_COUNT: begin
                    avg_count_next = pwdata[6:0];
                    if (CNT_W'(wslot_reg) >= n_new) begin
                        wslot_next = '0;
                    end
                    if (32'(n_new) < 32'(MAX_HISTORY)) begin
                        if (st_reg != ST_CLEAR) begin
                            st_next       = ST_CLEAR;
                            clr_slot_next = SLOT_CW'(n_new);
                            clr_low_next  = '0;
                        end else if (SLOT_CW'(n_new) < clr_slot_reg) begin
                            st_next       = ST_CLEAR;
                            clr_slot_next = SLOT_CW'(n_new);
                            clr_low_next  = '0;
                        end
                    end
                end
                REG_LOG_MODE: log_mode_next = pwdata[1:0];
                REG_REJECT:   reject_next   = pwdata[0];
                REG_PAUSE:    pause_next    = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_count_reg <= 7'd1;
            log_mode_reg  <= '0;
            reject_reg    <= 1'b1;
            pause_reg     <= 1'b0;
            wslot_reg     <= '0;
            st_reg        <= ST_CLEAR;
            clr_slot_reg  <= '0;
            clr_low_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            mv_reg        <= 1'b0;
        end else begin
            avg_count_reg <= avg_count_next;
            log_mode_reg  <= log_mode_next;
            reject_reg    <= reject_next;
            pause_reg     <= pause_next;
            wslot_reg     <= wslot_next;
            st_reg        <= st_next;
            clr_slot_reg  <= clr_slot_next;
            clr_low_reg   <= clr_low_next;
            rd_pend_reg   <= rd_pend_next;
            mv_reg        <= mv_next;
        end
        rd_slot_reg <= rd_slot_next;
        sum_reg     <= sum_next;
        res_reg     <= res_next;
        inv_reg     <= inv_next;
        if (s_valid && s_ready) begin
            it_ch_reg   <= s_channel;
            it_bin_reg  <= s_bin_index;
            it_val_reg  <= s_sample_value;
            it_done_reg <= s_frame_done;
        end
        if (mo_load) begin
            mo_ch_reg   <= it_ch_reg;
            mo_bin_reg  <= it_bin_reg;
            mo_val_reg  <= res_reg;
            mo_inv_reg  <= inv_reg;
            mo_done_reg <= it_done_reg;
        end
    end

    // history memory with a write port and a read port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= mem[mem_ra];
    end

    fhad_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .sum      (sum_reg),
        .count    (n_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    fhad_log u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .arg     (log_arg[SAMPLE_W-1:0]),
        .twenty  (log_mode_reg == LOG_TWENTY),
        .done    (log_done),
        .value   (log_val)
    );

    assign m_valid          = mv_reg;
    assign m_out_channel    = mo_ch_reg;
    assign m_out_bin        = mo_bin_reg;
    assign m_mean_value     = mo_val_reg;
    assign m_log_invalid    = mo_inv_reg;
    assign m_out_frame_done = mo_done_reg;

endmodule

FILE: tb/frame_history_averager_db_core_tb.sv
// frame_history_averager_db_core_tb: self-checking bench for the frame history averager
// depends on fhad_pkg and frame_history_averager_db_core; predicts every result word itself
`timescale 1ns / 100ps

module frame_history_averager_db_core_tb;
    import fhad_pkg::*;

    localparam int  HIST_DEPTH   = 64;
    localparam int  BIN_COUNT    = 4096;
    // long enough to cover any trailing work of the worst word
    localparam int  SETTLE_CYCLES = 400;
    // the history clear after reset or a count write is the longest quiet stretch
    localparam int  QUIET_LIMIT  = 10_000_000;
    localparam logic [1:0] LOG_LINEAR = 2'd0;
    localparam logic [1:0] LOG_SPARE  = 2'd3;  // unused code, behaves as linear
    localparam longint OFFSET_001 = 66;
    localparam longint TEN_LOG2   = 50504453;
    localparam longint TWENTY_LOG2 = 101008905;

    typedef struct {
        logic [2:0]  chan;
        logic [11:0] bin;
        logic [31:0] value;
        logic        invalid;
        logic        last;
    } avg_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_channel = '0;
    logic [11:0] s_bin_index = '0;
    logic signed [31:0] s_sample_value = '0;
    logic        s_frame_done = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_out_channel;
    logic [11:0] m_out_bin;
    logic signed [31:0] m_mean_value;
    logic        m_log_invalid;
    logic        m_out_frame_done;

    // predictor state: sparse history, absent entries read as zero
    int          history [int];
    int unsigned slot_now = 0;
    int unsigned avg_count = 1;
    logic [1:0]  mode_now = LOG_LINEAR;
    logic        rejecting = 1'b1;
    logic        paused = 1'b0;

    avg_word_t   pending_means [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          send_gaps = 1'b1;
    bit          recv_stalls = 1'b1;

    frame_history_averager_db_core i_dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned used_slots();
        if (avg_count < 1) return 1;
        if (avg_count > HIST_DEPTH) return HIST_DEPTH;
        return avg_count;
    endfunction

    function automatic int hist_key(int unsigned slot, int unsigned ch, int unsigned bin);
        return slot * 8 * BIN_COUNT + ch * BIN_COUNT + bin;
    endfunction

    // log2 of a positive q16.16 value, q.24, by repeated squaring of the mantissa
    function automatic longint log2_fixed(longint unsigned a);
        int unsigned e;
        longint unsigned y;
        longint frac;
        e = 0;
        frac = 0;
        while (e < 31 && (a >> (e + 1)) != 0) e++;
        y = a << (31 - e);
        for (int i = 0; i < 24; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(e) - 16) * 16777216 + frac;
    endfunction

    // rounding helpers, ties away from zero
    function automatic longint div_nearest(longint s, longint unsigned n);
        longint unsigned mag;
        longint unsigned q;
        mag = (s < 0) ? longint'(-s) : s;
        q = (mag + n / 2) / n;
        return (s < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint q24_to_q16(longint p);
        longint unsigned mag;
        longint unsigned q;
        mag = (p < 0) ? longint'(-p) : p;
        q = (mag + 64'h8000_0000) >> 32;
        return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    // stores the sample, advances the slot and queues the result word if one is due
    task automatic predict_mean(logic [2:0] ch, logic [11:0] bin, logic [31:0] raw,
                                logic done);
        int unsigned n;
        int unsigned slot;
        longint sum;
        longint mean;
        longint arg;
        longint db;
        avg_word_t w;
        if (rejecting) return;
        n = used_slots();
        slot = (slot_now >= n) ? 0 : slot_now;
        history[hist_key(slot, ch, bin)] = int'(raw);
        sum = 0;
        for (int unsigned s = 0; s < n; s++) begin
            if (history.exists(hist_key(s, ch, bin)))
                sum += longint'(history[hist_key(s, ch, bin)]);
        end
        mean = div_nearest(sum, n);
        if (done) slot = (slot + 1 >= n) ? 0 : slot + 1;
        slot_now = slot;
        w.chan = ch;
        w.bin = bin;
        w.last = done;
        w.invalid = 1'b0;
        w.value = mean[31:0];
        if (mode_now == LOG_TEN || mode_now == LOG_TWENTY) begin
            arg = mean + OFFSET_001;
            if (arg <= 0) begin
                w.invalid = 1'b1;
                w.value = 32'h8000_0000;
            end else begin
                db = q24_to_q16(log2_fixed(arg) *
                                ((mode_now == LOG_TEN) ? TEN_LOG2 : TWENTY_LOG2));
                w.value = db[31:0];
            end
        end
        if (!paused) pending_means.insert(pending_means.size(), w);
    endtask

    // ---------------------------------------------------------------- drivers

    // two-phase register write; the bench copy changes along with the block
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        int unsigned n;
        int doomed [$];
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_AVG_COUNT: begin
                avg_count = val[6:0];
                n = used_slots();
                // slots beyond the new depth are cleared
                foreach (history[k]) if (k / (8 * BIN_COUNT) >= n) doomed.insert(doomed.size(), k);
                foreach (doomed[i]) history.delete(doomed[i]);
                if (slot_now >= n) slot_now = 0;
            end
            REG_LOG_MODE: mode_now = val[1:0];
            REG_REJECT:   rejecting = val[0];
            REG_PAUSE:    paused = val[0];
            default: ;
        endcase
    endtask

    // one input word; valid stays high across back-to-back words
    task automatic send_word(logic [2:0] ch, logic [11:0] bin, logic [31:0] val,
                             logic done);
        if (send_gaps && $urandom_range(0, 99) < 19) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 40);
        end
        s_valid <= 1'b1;
        s_channel <= ch;
        s_bin_index <= bin;
        s_sample_value <= val;
        s_frame_done <= done;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_mean(ch, bin, val, done);
    endtask

    // waits until every result word is back, then lets trailing work finish
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 6))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom_range(0, 2000) - 1000;
            4: return $urandom_range(0, 32'h00FF_FFFF);
            5: return -$urandom_range(0, 200);
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
        endcase
    endfunction

    // mostly a handful of bins so history builds up, sometimes anywhere
    task automatic send_random(int count);
        logic [11:0] bin;
        for (int i = 0; i < count; i++) begin
            bin = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 3));
            send_word(3'($urandom()), bin, rand_sample(), $urandom_range(0, 7) == 0);
        end
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge aclk) begin
        avg_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_means.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: ch %0d bin %0d value %0d",
                             m_out_channel, m_out_bin, m_mean_value);
            end else begin
                w = pending_means.pop_front();
                if (m_out_channel !== w.chan || m_out_bin !== w.bin ||
                    m_mean_value !== w.value || m_log_invalid !== w.invalid ||
                    m_out_frame_done !== w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ch %0d bin %0d value %0d inv %0b last %0b, got ch %0d bin %0d value %0d inv %0b last %0b",
                                 w.chan, w.bin, $signed(w.value), w.invalid, w.last,
                                 m_out_channel, m_out_bin, m_mean_value, m_log_invalid,
                                 m_out_frame_done);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= recv_stalls ? ($urandom_range(0, 99) >= 19) : 1'b1;
    end

    // watchdog on cycles with no traffic at all
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pwrite))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("frame_history_averager_db_core_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // reject is set out of reset: words are swallowed with no result
    task automatic test_reject_at_reset();
        send_word(3'd1, 12'd7, 32'h0001_0000, 1'b1);
        send_word(3'd7, 12'd4095, 32'h8000_0000, 1'b0);
        drain();
        write_reg(REG_REJECT, 32'd0);
        write_reg(REG_PAUSE, 32'd0);
    endtask

    // extremes, slot advance, both log modes and pausing at a depth of five
    task automatic test_directed();
        write_reg(REG_AVG_COUNT, 32'd5);
        write_reg(REG_LOG_MODE, 32'(LOG_LINEAR));
        drain();
        send_word(3'd0, 12'd0, 32'h7FFF_FFFF, 1'b1);
        send_word(3'd0, 12'd0, 32'h7FFF_FFFF, 1'b1);
        send_word(3'd7, 12'd4095, 32'h8000_0000, 1'b1);
        send_word(3'd7, 12'd4095, 32'h8000_0000, 1'b0);
        send_word(3'd3, 12'd2730, 32'd3, 1'b1);      // rounds away from zero
        send_word(3'd4, 12'd1365, -32'sd3, 1'b1);
        send_word(3'd5, 12'd100, 32'd0, 1'b0);
        drain();
        write_reg(REG_LOG_MODE, 32'(LOG_TEN));
        drain();
        send_word(3'd6, 12'd200, 32'd0, 1'b0);       // log of just the offset
        send_word(3'd6, 12'd201, -32'sd66, 1'b0);    // averaged over five slots, the argument stays positive
        send_word(3'd6, 12'd202, -32'sd65, 1'b0);
        send_word(3'd0, 12'd0, 32'h7FFF_FFFF, 1'b1);
        send_word(3'd2, 12'd9, 32'h0001_0000, 1'b0);
        drain();
        write_reg(REG_LOG_MODE, 32'(LOG_TWENTY));
        drain();
        send_word(3'd7, 12'd4095, 32'h8000_0000, 1'b0);
        send_word(3'd2, 12'd9, 32'h0064_0000, 1'b1);
        send_word(3'd1, 12'd1, 32'h7FFF_0000, 1'b0);
        drain();
        write_reg(REG_PAUSE, 32'd1);
        drain();
        send_word(3'd2, 12'd9, 32'h0000_1000, 1'b1);
        send_word(3'd2, 12'd9, 32'h0000_2000, 1'b1);
        drain();
        write_reg(REG_PAUSE, 32'd0);
        write_reg(REG_LOG_MODE, 32'(LOG_SPARE));
        drain();
        send_word(3'd2, 12'd9, 32'h0000_3000, 1'b0);
        send_word(3'd7, 12'd4095, -32'sd1, 1'b0);
        drain();
    endtask

    // over-range count acts as full depth; all log modes in turn, one paused spell
    task automatic test_full_depth_modes();
        write_reg(REG_AVG_COUNT, 32'd127);
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_LOG_MODE, 32'(m));
            drain();
            send_random(170);
            drain();
        end
        write_reg(REG_PAUSE, 32'd1);
        drain();
        send_random(30);
        drain();
        write_reg(REG_PAUSE, 32'd0);
    endtask

    // zero count acts as one slot
    task automatic test_single_slot();
        write_reg(REG_AVG_COUNT, 32'd0);
        write_reg(REG_LOG_MODE, 32'(LOG_TWENTY));
        drain();
        send_random(200);
        drain();
        write_reg(REG_LOG_MODE, 32'(LOG_TEN));
        drain();
        send_random(200);
        drain();
    endtask

    // full depth again, with a run of no idling and a pause for all results
    task automatic test_back_to_back();
        write_reg(REG_AVG_COUNT, 32'd64);
        write_reg(REG_LOG_MODE, 32'(LOG_LINEAR));
        drain();
        send_random(250);
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        send_random(200);
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        s_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        send_random(250);
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reject_at_reset();
        test_directed();
        test_full_depth_modes();
        test_single_slot();
        test_back_to_back();
        if (mismatches == 0 && pending_means.size() == 0)
            $display("frame_history_averager_db_core_tb: PASS");
        else
            $display("frame_history_averager_db_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/fhad_pkg.sv
sv/fhad_div.sv
sv/fhad_log.sv
sv/frame_history_averager_db_core.sv
tb/frame_history_averager_db_core_tb.sv
